// ----- sv/atoib_pkg.sv -----
`timescale 1ns / 1ps

package atoib_pkg;

  // Alphabet storage: two 64-bit registers, one byte per digit value
  localparam int SYM_SLOTS        = 16;
  localparam int MAX_SYMBOLS_DEF  = 16;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_INDEX_W      = 2;
  localparam int BASE_W           = 5;
  localparam int DIGIT_W          = 4;
  localparam int VALUE_W          = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SIZE    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

// ----- sv/string_to_integer_any_base.sv -----
`timescale 1ns / 1ps

// String to integer parser with a configurable digit alphabet.
// Input channel (in_valid/in_ready): one character byte per transaction, with
// in_last marking the final byte of a string. Result channel
// (out_valid/out_ready): one transaction per string, carrying the signed
// 32-bit value and a flag that rejects an invalid alphabet (value is 0 then).
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0 symbols low, 1 symbols high, 2 base size); the user must write only
// while no string is in flight, as the block itself does not enforce it.
// Throughput: one byte per cycle unless a final byte waits for the output
// slot. Each byte is held in an input register, then one alphabet compare
// plus a 32x5 multiply-subtract updates the accumulator; that update loop
// sets the rate. A final byte's result is then held in the output register.
// Reset (synchronous, rst_n low) empties both registers, returns the parser
// to the leading-whitespace phase and clears the alphabet registers.
// When the receiver stalls, the result is held in the output register and
// bytes keep flowing until a second final byte has to wait for that slot;
// then in_ready drops.
module string_to_integer_any_base
  import atoib_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_symbol,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                   out_base_rejected
);

  localparam logic [BASE_W-1:0] MaxSym = BASE_W'(MAX_SYMBOLS);

  // Configuration registers
  logic [CFG_DATA_W-1:0] sym_low_r;
  logic [CFG_DATA_W-1:0] sym_high_r;
  logic [BASE_W-1:0]     base_size_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_symbol_r;
  logic       s1_last_r;

  // Parser state
  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;

  // Output register
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic                 out_rej_r;

  logic [8*SYM_SLOTS-1:0] sym_all;
  logic [SYM_SLOTS-1:0]   bad_sym;
  logic                   alpha_ok;
  logic [SYM_SLOTS-1:0]   hit;
  logic                   digit_hit;
  logic [DIGIT_W-1:0]     digit;
  logic                   out_free;
  logic                   s1_fire;
  logic                   neg_byte;
  logic [VALUE_W-1:0]     acc_byte;
  logic [VALUE_W-1:0]     result_val;

  assign sym_all = {sym_high_r, sym_low_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r   <= '0;
      sym_high_r  <= '0;
      base_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYMBOLS_LOW:  sym_low_r   <= cfg_wdata;
        CFG_SYMBOLS_HIGH: sym_high_r  <= cfg_wdata;
        CFG_BASE_SIZE:    base_size_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Check the alphabet: each symbol in use must be nonzero, not a sign or
  // whitespace, and unique
  always_comb begin
    bad_sym = '0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (BASE_W'(i) < base_size_r) begin
        if ((sym_all[8*i +: 8] == 8'h00) || is_sign(sym_all[8*i +: 8]) ||
            is_space(sym_all[8*i +: 8])) begin
          bad_sym[i] = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((BASE_W'(j) < base_size_r) && (sym_all[8*j +: 8] == sym_all[8*i +: 8])) begin
            bad_sym[i] = 1'b1;
          end
        end
      end
    end
    alpha_ok = (base_size_r >= BASE_W'(2)) && (base_size_r <= MaxSym) && !(|bad_sym);
  end

  // Match the held byte against the symbols in use; lowest index wins
  always_comb begin
    hit   = '0;
    digit = '0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      hit[i] = (BASE_W'(i) < base_size_r) && (sym_all[8*i +: 8] == s1_symbol_r) &&
               (s1_symbol_r != 8'h00);
    end
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        digit = DIGIT_W'(i);
      end
    end
    digit_hit = |hit;
  end

  // Handshake: the input register drains unless a final byte meets a full output slot
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  // Capture the incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_symbol_r <= in_symbol;
      s1_last_r   <= in_last;
    end
  end

  // Advance the parser by one byte
  always_comb begin
    phase_nxt = phase_r;
    neg_byte  = neg_r;
    acc_byte  = acc_r;
    if (s1_fire) begin
      if ((phase_r == PH_SPACE) && is_space(s1_symbol_r)) begin
        phase_nxt = PH_SPACE;
      end else if (((phase_r == PH_SPACE) || (phase_r == PH_SIGN)) &&
                   is_sign(s1_symbol_r)) begin
        if (s1_symbol_r == CH_MINUS) begin
          neg_byte = !neg_r;
        end
        phase_nxt = PH_SIGN;
      end else if (phase_r != PH_DONE) begin
        if (digit_hit) begin
          acc_byte  = VALUE_W'(acc_r * VALUE_W'(base_size_r)) - VALUE_W'(digit);
          phase_nxt = PH_DIGIT;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
    end
    neg_nxt = neg_byte;
    acc_nxt = acc_byte;
    // Drop the string state once the final byte is consumed
    if (s1_fire && s1_last_r) begin
      phase_nxt = PH_SPACE;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Form the result from the accumulator after this byte
  always_comb begin
    if (!alpha_ok) begin
      result_val = '0;
    end else if (neg_byte) begin
      result_val = acc_byte;
    end else begin
      result_val = VALUE_W'(0) - acc_byte;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_value_r <= result_val;
      out_rej_r   <= !alpha_ok;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign out_base_rejected = out_rej_r;

  // A rejected alphabet always reports zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_base_rejected |-> out_value == '0)
    else $error("rejected alphabet with nonzero value");

  // Reset returns the parser to its idle state
  assert property (@(posedge clk)
    !rst_n |=> (phase_r == PH_SPACE) && !neg_r && (acc_r == '0) && !out_valid_r)
    else $error("parser state not cleared by reset");

  // Consuming a final byte clears the string state and fills the output slot
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> (phase_r == PH_SPACE) && !neg_r && (acc_r == '0) && out_valid_r)
    else $error("final byte did not produce a result");

  // Backpressure only comes from a held byte
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_last_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

endmodule

// ----- tb/string_to_integer_any_base_tb.sv -----
`timescale 1ns / 1ps

module string_to_integer_any_base_tb;
  import atoib_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CHARS = 50;
  localparam int RANDOM_PHASES = 9;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } char_txn_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      rejected;
  } parse_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = CFG_SYMBOLS_LOW;
  logic [CFG_DATA_W-1:0]         cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_symbol = 8'h00;
  logic                          in_last = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VALUE_W-1:0]     out_value;
  logic                          out_base_rejected;

  // Shadow of the configuration registers
  logic [63:0]       alpha_lo = '0;
  logic [63:0]       alpha_hi = '0;
  logic [BASE_W-1:0] radix = '0;

  // Parser state mirrored from the block
  phase_t            scan_phase = PH_SPACE;
  logic              negate = 1'b0;
  logic [31:0]       neg_acc = '0;

  // Alphabet being built for the next configuration
  logic [7:0]        alpha [16];

  char_txn_t         char_q[$];
  parse_result_t     parsed_q[$];
  int unsigned       chars_queued = 0;
  int unsigned       chars_taken = 0;
  int unsigned       send_gap_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  string_to_integer_any_base dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_symbol        (in_symbol),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_base_rejected(out_base_rejected)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic blank(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic [7:0] slot(input int i);
    if (i < 8) begin
      return alpha_lo[8*i +: 8];
    end
    return alpha_hi[8*(i-8) +: 8];
  endfunction

  function automatic int slots_in_use();
    return (radix > 16) ? 16 : int'(radix);
  endfunction

  function automatic logic alphabet_valid();
    int n;
    int i;
    int j;
    logic [7:0] c;
    if (radix < 2 || radix > 16) begin
      return 1'b0;
    end
    n = int'(radix);
    for (i = 0; i < n; i++) begin
      c = slot(i);
      if (c == 8'h00 || c == CH_PLUS || c == CH_MINUS || blank(c)) begin
        return 1'b0;
      end
      for (j = i + 1; j < n; j++) begin
        if (slot(j) == c) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Digit value of c, or -1 when c is not an active symbol
  function automatic int digit_value(input logic [7:0] c);
    int i;
    if (c == 8'h00) begin
      return -1;
    end
    for (i = 0; i < slots_in_use(); i++) begin
      if (slot(i) == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Advance the parser by one byte; queue the parsed value on the final byte
  function automatic void parse_char(input logic [7:0] c, input logic fin);
    int d;
    parse_result_t r;
    if (scan_phase == PH_SPACE && blank(c)) begin
      // skip leading whitespace
    end else if ((scan_phase == PH_SPACE || scan_phase == PH_SIGN) &&
                 (c == CH_PLUS || c == CH_MINUS)) begin
      if (c == CH_MINUS) begin
        negate = ~negate;
      end
      scan_phase = PH_SIGN;
    end else if (scan_phase != PH_DONE) begin
      d = digit_value(c);
      if (d >= 0) begin
        neg_acc = neg_acc * {27'd0, radix} - d;
        scan_phase = PH_DIGIT;
      end else begin
        scan_phase = PH_DONE;
      end
    end
    if (fin) begin
      if (alphabet_valid()) begin
        r.value = negate ? neg_acc : -neg_acc;
        r.rejected = 1'b0;
      end else begin
        r.value = '0;
        r.rejected = 1'b1;
      end
      parsed_q.push_back(r);
      scan_phase = PH_SPACE;
      negate = 1'b0;
      neg_acc = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  // Drive the input channel from the pending byte queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_symbol, in_last);
        chars_taken++;
      end
      // load the next byte once the current transaction is done
      if (!in_valid || in_ready) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_symbol <= char_q[0].symbol;
          in_last <= char_q[0].last;
          void'(char_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transaction against the oldest parsed value
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          report_mismatch("result with none pending, value", out_value, '0);
        end else begin
          if (out_value !== parsed_q[0].value) begin
            report_mismatch("value", out_value, parsed_q[0].value);
          end
          if (out_base_rejected !== parsed_q[0].rejected) begin
            report_mismatch("base_rejected", {31'd0, out_base_rejected},
                            {31'd0, parsed_q[0].rejected});
          end
          void'(parsed_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_gap_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic push_byte(input logic [7:0] c, input logic fin);
    char_txn_t t;
    t.symbol = c;
    t.last = fin;
    char_q.push_back(t);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      push_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Wait until every byte is taken and every result has come, then settle
  task automatic drain_and_settle();
    while (chars_taken != chars_queued || parsed_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Pack the alphabet and write all three registers
  task automatic apply_alphabet(input logic [63:0] base_word);
    logic [63:0] lo;
    logic [63:0] hi;
    int i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = alpha[i];
      hi[8*i +: 8] = alpha[i+8];
    end
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SYMBOLS_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_SYMBOLS_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_BASE_SIZE;
    cfg_wdata <= base_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_lo = lo;
    alpha_hi = hi;
    radix = base_word[BASE_W-1:0];
  endtask

  function automatic logic unusable(input logic [7:0] c);
    return c == 8'h00 || c == CH_PLUS || c == CH_MINUS || blank(c);
  endfunction

  // Fill the active slots with distinct legal symbols, the rest with noise
  task automatic build_alphabet(input int nbase);
    int n;
    int i;
    int j;
    logic ok;
    logic [7:0] c;
    n = (nbase > 16) ? 16 : nbase;
    for (i = 0; i < 16; i++) begin
      if (i < n) begin
        do begin
          c = 8'($urandom);
          ok = !unusable(c);
          for (j = 0; j < i; j++) begin
            if (alpha[j] == c) begin
              ok = 1'b0;
            end
          end
        end while (!ok);
        alpha[i] = c;
      end else begin
        alpha[i] = 8'($urandom);
      end
    end
  endtask

  function automatic logic [7:0] ws_byte();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] digit_byte();
    int n;
    n = slots_in_use();
    if (n == 0) begin
      return 8'($urandom);
    end
    return alpha[$urandom_range(n - 1)];
  endfunction

  function automatic logic [7:0] sign_byte();
    return $urandom_range(1) ? CH_MINUS : CH_PLUS;
  endfunction

  // Queue one string: mostly well formed, some noise and broken ones
  task automatic push_random_string();
    int kind;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      repeat ($urandom_range(2)) push_byte(ws_byte(), 1'b0);
      repeat ($urandom_range(3)) push_byte(sign_byte(), 1'b0);
      repeat ($urandom_range(9)) push_byte(digit_byte(), 1'b0);
    end else if (kind == 7) begin
      repeat ($urandom_range(5)) push_byte(8'($urandom), 1'b0);
    end else begin
      case ($urandom_range(2))
        0: begin
          push_byte(sign_byte(), 1'b0);
          push_byte(ws_byte(), 1'b0);
        end
        1: begin
          repeat ($urandom_range(1, 3)) push_byte(digit_byte(), 1'b0);
          push_byte(sign_byte(), 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 3)) push_byte(digit_byte(), 1'b0);
          push_byte(8'h00, 1'b0);
        end
      endcase
      repeat ($urandom_range(1, 3)) push_byte(digit_byte(), 1'b0);
    end
    if ($urandom_range(4) != 0) begin
      push_byte(digit_byte(), 1'b1);
    end else begin
      push_byte(8'($urandom), 1'b1);
    end
  endtask

  initial begin : stimulus
    int p;
    int i;
    int j;
    int k;
    int nb;
    int unsigned stop_at;
    logic [63:0] base_word;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(30, 67);

    // Reset alphabet is empty: expect rejection
    push_text("7");
    drain_and_settle();

    // Decimal alphabet: whitespace, sign runs, early stops, zero byte
    for (i = 0; i < 16; i++) begin
      alpha[i] = (i < 10) ? 8'h30 + 8'(i) : 8'h00;
    end
    apply_alphabet(64'd10);
    for (i = 9; i <= 13; i++) begin
      push_byte(8'(i), 1'b0);
    end
    push_byte(CH_SPACE, 1'b0);
    push_text("-+-42");
    push_text("+ 5");
    push_text("3-4");
    push_byte(8'h35, 1'b0);
    push_byte(8'h00, 1'b1);
    drain_and_settle();

    // Base 16 with extreme symbol bytes and junk above the base field; overflow
    alpha[0] = 8'h01;
    alpha[1] = 8'h80;
    alpha[2] = 8'h7f;
    for (i = 3; i < 15; i++) begin
      alpha[i] = 8'h41 + 8'(i - 3);
    end
    alpha[15] = 8'hff;
    apply_alphabet(64'hffff_ffff_ffff_fff0);
    push_byte(CH_MINUS, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    repeat (7) push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    drain_and_settle();

    // Random phases, each with its own alphabet
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        set_idling(67, 30);
      end else if (p == 6) begin
        set_idling(0, 0);
      end
      case (p)
        0: nb = 2;
        1: nb = 16;
        2: nb = 31;
        default: nb = $urandom_range(2, 16);
      endcase
      build_alphabet(nb);
      // duplicate symbol
      if (p == 4) begin
        i = $urandom_range(nb - 2);
        j = $urandom_range(i + 1, nb - 1);
        alpha[j] = alpha[i];
      end
      // sign, whitespace or zero as a symbol
      if (p == 6) begin
        k = $urandom_range(3);
        alpha[$urandom_range(nb - 1)] = (k == 0) ? 8'h00 :
                                        (k == 1) ? CH_PLUS :
                                        (k == 2) ? CH_MINUS : ws_byte();
      end
      base_word = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
      base_word[BASE_W-1:0] = nb[BASE_W-1:0];
      apply_alphabet(base_word);
      stop_at = chars_queued + PHASE_CHARS;
      while (chars_queued < stop_at) begin
        push_random_string();
      end
      drain_and_settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/atoib_pkg.sv
sv/string_to_integer_any_base.sv
tb/string_to_integer_any_base_tb.sv
